>>> hdl/ipv4dpc_pkg.sv
// shared constants, codes and types for the dotted-decimal address parser
`timescale 1ns / 1ps

package ipv4dpc_pkg;

    localparam int NUM_OCTETS = 4;
    localparam logic [2:0] FIELD_SAT = 3'd5;
    localparam logic [3:0] COUNT_SAT = 4'd15;
    localparam logic [3:0] BINARY_LEN = 4'd8;
    localparam logic [8:0] OCTET_MAX = 9'd255;
    localparam logic [8:0] ACC_SAT = 9'd256;

    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [7:0] CLASS_A_MAX = 8'd126;
    localparam logic [7:0] CLASS_B_MIN = 8'd128;
    localparam logic [7:0] CLASS_B_MAX = 8'd191;
    localparam logic [7:0] CLASS_C_MAX = 8'd223;
    localparam logic [7:0] CLASS_D_MAX = 8'd239;
    localparam logic [7:0] LOOPBACK_NET = 8'd127;

    localparam int OUT_DATA_W = 112;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_TOO_FEW   = 4'd1,
        ERR_TOO_MANY  = 4'd2,
        ERR_EMPTY     = 4'd3,
        ERR_BAD_CHAR  = 4'd4,
        ERR_MIXED     = 4'd5,
        ERR_BINARY    = 4'd6,
        ERR_LEAD_ZERO = 4'd7,
        ERR_RANGE     = 4'd8
    } err_code_t;

    typedef enum logic [2:0] {
        CLS_A        = 3'd0,
        CLS_B        = 3'd1,
        CLS_C        = 3'd2,
        CLS_D        = 3'd3,
        CLS_E        = 3'd4,
        CLS_ZERO_NET = 3'd5,
        CLS_LOOPBACK = 3'd6
    } class_code_t;

    // per-octet flag set collected while parsing one text
    typedef struct packed {
        logic [3:0] lead_zero;
        logic [3:0] bad_char;
        logic [3:0] empty;
        logic [3:0] binary;
        logic [3:0] range;
    } octet_flags_t;

endpackage

>>> hdl/ipv4_dotted_parse_classify_top.sv
// dotted-decimal ipv4 text parser with classful classification
// path: the word carrying tlast is registered into the pending stage, then its verdict into the output register
// throughput: one character word per cycle; a finished verdict waits in a one-deep
// pending stage behind the output register, and input stalls only while both hold a
// verdict and m_tready is low
// reset: rst_n clears the parse state, the pending stage and the output valid
`timescale 1ns / 1ps

module ipv4_dotted_parse_classify_top
    import ipv4dpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_code
    input  logic                  s_tlast,   // end_of_text
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] error_code, [5:4] error_octet, [37:6] address_word, [40:38] class_code,
    // [45:41] prefix_len, [77:46] network_word, [109:78] host_word, [111:110] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser    // [0] addr_valid
);

    // running parse state
    logic [2:0]   fi_reg;
    logic [3:0]   dc_reg;
    logic [8:0]   acc_reg;
    logic         z_reg;
    octet_flags_t flags_reg;
    logic [7:0]   oct_reg [NUM_OCTETS];

    logic [2:0]   fi_next;
    logic [3:0]   dc_next;
    logic [8:0]   acc_next;
    logic         z_next;
    octet_flags_t flags_next;
    logic [7:0]   oct_next [NUM_OCTETS];

    // pending stage: one finished text
    logic         pend_valid_reg;
    logic [2:0]   pend_fi_reg;
    octet_flags_t pend_flags_reg;
    logic [7:0]   pend_oct_reg [NUM_OCTETS];

    // output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;
    logic                  m_tuser_next;

    logic in_accept;
    logic out_load;
    logic pend_adv;
    logic is_dot;
    logic is_digit;
    logic [12:0] acc_mul;
    logic [3:0]  bit_sel;

    assign out_load  = !m_tvalid_reg || m_tready;
    assign pend_adv  = pend_valid_reg && out_load;
    assign s_tready  = !pend_valid_reg || out_load;
    assign in_accept = s_tvalid && s_tready;

    assign is_dot   = (s_tdata == CHAR_DOT);
    assign is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    // acc * 10 + digit
    assign acc_mul  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {9'd0, s_tdata[3:0]};
    assign bit_sel  = (fi_reg < 3'(NUM_OCTETS)) ? (4'b0001 << fi_reg[1:0]) : 4'b0000;

    always_comb
    begin
        fi_next    = fi_reg;
        dc_next    = dc_reg;
        acc_next   = acc_reg;
        z_next     = z_reg;
        flags_next = flags_reg;
        oct_next   = oct_reg;
        if (!is_dot)
        begin
            if (dc_reg == 4'd1 && acc_reg == 9'd0)
            begin
                flags_next.lead_zero = flags_next.lead_zero | bit_sel;
            end
            if (is_digit)
            begin
                if (acc_reg >= ACC_SAT || acc_mul > {4'd0, ACC_SAT})
                begin
                    acc_next = ACC_SAT;
                end
                else
                begin
                    acc_next = acc_mul[8:0];
                end
            end
            else
            begin
                flags_next.bad_char = flags_next.bad_char | bit_sel;
            end
            if (s_tdata != CHAR_ZERO && s_tdata != CHAR_ONE)
            begin
                z_next = 1'b0;
            end
            if (dc_reg < COUNT_SAT)
            begin
                dc_next = dc_reg + 4'd1;
            end
        end
        // a dot closes the field; so does the last word when it is not a dot
        if (is_dot || s_tlast)
        begin
            if (dc_next == 4'd0)
            begin
                flags_next.empty = flags_next.empty | bit_sel;
            end
            if (dc_next == BINARY_LEN && z_next)
            begin
                flags_next.binary = flags_next.binary | bit_sel;
            end
            if (acc_next > OCTET_MAX)
            begin
                flags_next.range = flags_next.range | bit_sel;
            end
            if (fi_reg < 3'(NUM_OCTETS))
            begin
                oct_next[fi_reg[1:0]] = acc_next[7:0];
            end
            if (fi_reg < FIELD_SAT)
            begin
                fi_next = fi_reg + 3'd1;
            end
            dc_next  = 4'd0;
            acc_next = 9'd0;
            z_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg    <= '0;
            dc_reg    <= '0;
            acc_reg   <= '0;
            z_reg     <= 1'b1;
            flags_reg <= '0;
            for (int i = 0; i < NUM_OCTETS; i++)
            begin
                oct_reg[i] <= '0;
            end
        end
        else if (in_accept)
        begin
            if (s_tlast)
            begin
                fi_reg    <= '0;
                dc_reg    <= '0;
                acc_reg   <= '0;
                z_reg     <= 1'b1;
                flags_reg <= '0;
                for (int i = 0; i < NUM_OCTETS; i++)
                begin
                    oct_reg[i] <= '0;
                end
            end
            else
            begin
                fi_reg    <= fi_next;
                dc_reg    <= dc_next;
                acc_reg   <= acc_next;
                z_reg     <= z_next;
                flags_reg <= flags_next;
                oct_reg   <= oct_next;
            end
        end
    end

    // pending stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (in_accept && s_tlast)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (pend_adv)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && s_tlast)
        begin
            pend_fi_reg    <= fi_next;
            pend_flags_reg <= flags_next;
            pend_oct_reg   <= oct_next;
        end
    end

    // verdict logic on the pending stage
    always_comb
    begin
        err_code_t   err;
        logic [1:0]  eoct;
        logic [31:0] addr;
        logic [31:0] mask;
        class_code_t cls;
        logic [4:0]  plen;
        logic [7:0]  a;

        err  = ERR_NONE;
        eoct = 2'd0;
        a    = pend_oct_reg[0];
        addr = {pend_oct_reg[0], pend_oct_reg[1], pend_oct_reg[2], pend_oct_reg[3]};

        if (pend_fi_reg < 3'(NUM_OCTETS))
        begin
            err = ERR_TOO_FEW;
        end
        else if (pend_fi_reg > 3'(NUM_OCTETS))
        begin
            err = ERR_TOO_MANY;
        end
        else
        begin
            for (int i = NUM_OCTETS - 1; i >= 0; i--)
            begin
                if (pend_flags_reg.empty[i])
                begin
                    err  = ERR_EMPTY;
                    eoct = 2'(i);
                end
                else if (pend_flags_reg.bad_char[i])
                begin
                    err  = ERR_BAD_CHAR;
                    eoct = 2'(i);
                end
            end
            if (err == ERR_NONE && pend_flags_reg.binary != 4'b0000)
            begin
                err = (pend_flags_reg.binary != 4'b1111) ? ERR_MIXED : ERR_BINARY;
            end
            if (err == ERR_NONE)
            begin
                for (int i = NUM_OCTETS - 1; i >= 0; i--)
                begin
                    if (pend_flags_reg.lead_zero[i])
                    begin
                        err  = ERR_LEAD_ZERO;
                        eoct = 2'(i);
                    end
                    else if (pend_flags_reg.range[i])
                    begin
                        err  = ERR_RANGE;
                        eoct = 2'(i);
                    end
                end
            end
        end

        if (a inside {[8'd1 : CLASS_A_MAX]})
        begin
            cls = CLS_A; plen = 5'd8; mask = 32'hFF00_0000;
        end
        else if (a inside {[CLASS_B_MIN : CLASS_B_MAX]})
        begin
            cls = CLS_B; plen = 5'd16; mask = 32'hFFFF_0000;
        end
        else if (a inside {[CLASS_B_MAX + 8'd1 : CLASS_C_MAX]})
        begin
            cls = CLS_C; plen = 5'd24; mask = 32'hFFFF_FF00;
        end
        else if (a inside {[CLASS_C_MAX + 8'd1 : CLASS_D_MAX]})
        begin
            cls = CLS_D; plen = 5'd0; mask = 32'h0000_0000;
        end
        else if (a > CLASS_D_MAX)
        begin
            cls = CLS_E; plen = 5'd0; mask = 32'h0000_0000;
        end
        else if (a == 8'd0)
        begin
            cls = CLS_ZERO_NET; plen = 5'd0; mask = 32'h0000_0000;
        end
        else
        begin
            // only the loopback network is left
            cls = (a == LOOPBACK_NET) ? CLS_LOOPBACK : CLS_LOOPBACK;
            plen = 5'd0; mask = 32'h0000_0000;
        end

        m_tuser_next = (err == ERR_NONE);
        if (err == ERR_NONE)
        begin
            m_tdata_next = {2'b00, addr & ~mask, addr & mask, plen, cls, addr, eoct, err};
        end
        else
        begin
            m_tdata_next = {2'b00, 32'd0, 32'd0, 5'd0, 3'd0, 32'd0, eoct, err};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= pend_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_adv)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
